@@ hw/rtl/fpdc_pkg.sv @@
// shared types and constants of the five-point derivative check
`timescale 1ns / 1ps

package fpdc_pkg;

  localparam int unsigned MaskW      = 5;
  localparam int unsigned HalfStepW  = 16;
  // twelve times the largest half step fits in 20 bits
  localparam int unsigned DivisorW   = HalfStepW + 4;
  localparam int unsigned DerivW     = 25;
  localparam int unsigned OutTdataW  = 32;
  localparam int unsigned StatusW    = 2;

  localparam logic [HalfStepW-1:0] HalfStepRst = HalfStepW'(1);

  typedef enum logic [StatusW-1:0] {
    ST_VALID     = 2'd0,
    ST_UNDEFINED = 2'd1,
    ST_UNSTABLE  = 2'd2
  } status_e;

  // control that travels with every word down the pipeline
  typedef struct packed {
    logic    valid;
    logic    neg;
    status_e status;
  } ctl_t;

endpackage

@@ hw/rtl/fpdc_front.sv @@
// front stages: numerator, hump tests, status, magnitude and divisor
`timescale 1ns / 1ps

module fpdc_front #(
  parameter int unsigned SAMPLE_BITS   = 16,
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [SAMPLE_BITS-1:0]     far_left_i,
  input  logic signed [SAMPLE_BITS-1:0]     near_left_i,
  input  logic signed [SAMPLE_BITS-1:0]     mid_i,
  input  logic signed [SAMPLE_BITS-1:0]     near_right_i,
  input  logic signed [SAMPLE_BITS-1:0]     far_right_i,
  input  logic [fpdc_pkg::MaskW-1:0]        mask_i,
  input  logic [fpdc_pkg::HalfStepW-1:0]    half_step_i,
  output fpdc_pkg::ctl_t                    ctl_o,
  output logic [SAMPLE_BITS+3+FRACTION_BITS:0] mag_o,
  output logic [fpdc_pkg::DivisorW-1:0]     divisor_o
);

  import fpdc_pkg::*;

  localparam int unsigned NumW = SAMPLE_BITS + 5;
  localparam int unsigned DW   = SAMPLE_BITS + 2;
  localparam int unsigned MagW = NumW - 1 + FRACTION_BITS;

  // stage one
  logic signed [NumW-1:0] e1, e2, e4, e5, num_d, num_q;
  logic signed [DW-1:0]   x1, x2, x3, x4, x5;
  logic signed [DW-1:0]   dr_d, dl_d, dsl_d, dsr_d;
  logic signed [DW-1:0]   dr_q, dl_q, dsl_q, dsr_q;
  logic                   mono_d, rh_d, lh_d, bad_d;
  logic                   mono_q, rh_q, lh_q, bad_q, v1_q;

  assign e1 = NumW'(far_left_i);
  assign e2 = NumW'(near_left_i);
  assign e4 = NumW'(near_right_i);
  assign e5 = NumW'(far_right_i);
  assign num_d = e1 - e5 + ((e4 - e2) <<< 3);

  assign x1 = DW'(far_left_i);
  assign x2 = DW'(near_left_i);
  assign x3 = DW'(mid_i);
  assign x4 = DW'(near_right_i);
  assign x5 = DW'(far_right_i);
  assign dr_d  = (x4 <<< 1) - x3 - x5;
  assign dl_d  = x3 - x1;
  assign dsl_d = (x2 <<< 1) - x1 - x3;
  assign dsr_d = x5 - x3;

  assign mono_d = (x1 < x2 && x2 < x3 && x3 < x4 && x4 < x5) ||
                  (x1 > x2 && x2 > x3 && x3 > x4 && x4 > x5);
  assign rh_d   = (x4 > x3 && x4 > x5) || (x4 < x3 && x4 < x5);
  assign lh_d   = (x2 > x1 && x2 > x3) || (x2 < x1 && x2 < x3);
  assign bad_d  = |mask_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q  <= num_d;
      dr_q   <= dr_d;
      dl_q   <= dl_d;
      dsl_q  <= dsl_d;
      dsr_q  <= dsr_d;
      mono_q <= mono_d;
      rh_q   <= rh_d;
      lh_q   <= lh_d;
      bad_q  <= bad_d;
    end
  end

  // stage two
  logic [DW-1:0]           a_dr, a_dl, a_dsl, a_dsr;
  logic [NumW-1:0]         a_num;
  logic                    unst;
  ctl_t                    ctl_d, ctl_q;
  logic [MagW-1:0]         mag_d, mag_q;
  logic [HalfStepW-1:0]    hs;
  logic [DivisorW-1:0]     div_d, div_q;

  assign a_dr  = dr_q[DW-1]  ? DW'(-dr_q)  : DW'(dr_q);
  assign a_dl  = dl_q[DW-1]  ? DW'(-dl_q)  : DW'(dl_q);
  assign a_dsl = dsl_q[DW-1] ? DW'(-dsl_q) : DW'(dsl_q);
  assign a_dsr = dsr_q[DW-1] ? DW'(-dsr_q) : DW'(dsr_q);
  assign a_num = num_q[NumW-1] ? NumW'(-num_q) : NumW'(num_q);

  assign unst = !mono_q && ((rh_q && (lh_q || a_dr > a_dl)) || (lh_q && a_dsl > a_dsr));

  always_comb begin
    ctl_d.valid = v1_q;
    ctl_d.neg   = num_q[NumW-1];
    if (bad_q) begin
      ctl_d.status = ST_UNDEFINED;
    end else if (unst) begin
      ctl_d.status = ST_UNSTABLE;
    end else begin
      ctl_d.status = ST_VALID;
    end
  end

  // magnitude never reaches the top bit of the signed numerator
  assign mag_d = MagW'(a_num[NumW-2:0]) << FRACTION_BITS;

  // zero spacing acts as one
  assign hs    = (half_step_i == '0) ? HalfStepW'(1) : half_step_i;
  assign div_d = (DivisorW'(hs) << 3) + (DivisorW'(hs) << 2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= mag_d;
      div_q <= div_d;
    end
  end

  assign ctl_o     = ctl_q;
  assign mag_o     = mag_q;
  assign divisor_o = div_q;

endmodule

@@ hw/rtl/fpdc_div_step.sv @@
// one registered restoring-division step, one quotient bit
`timescale 1ns / 1ps

module fpdc_div_step #(
  parameter int unsigned MAG_W = 28
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  fpdc_pkg::ctl_t                ctl_i,
  input  logic [fpdc_pkg::DivisorW-1:0] rem_i,
  input  logic [MAG_W-1:0]              dq_i,
  input  logic [fpdc_pkg::DivisorW-1:0] divisor_i,
  output fpdc_pkg::ctl_t                ctl_o,
  output logic [fpdc_pkg::DivisorW-1:0] rem_o,
  output logic [MAG_W-1:0]              dq_o,
  output logic [fpdc_pkg::DivisorW-1:0] divisor_o
);

  import fpdc_pkg::*;

  logic [DivisorW:0]   trial, diff;
  logic                ge;
  ctl_t                ctl_q;
  logic [DivisorW-1:0] rem_d, rem_q, div_q;
  logic [MAG_W-1:0]    dq_d, dq_q;

  // dividend bits shift out the top while quotient bits shift in below
  assign trial = {rem_i, dq_i[MAG_W-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign ge    = trial >= {1'b0, divisor_i};
  assign rem_d = ge ? diff[DivisorW-1:0] : trial[DivisorW-1:0];
  assign dq_d  = {dq_i[MAG_W-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      dq_q  <= dq_d;
      div_q <= divisor_i;
    end
  end

  assign ctl_o     = ctl_q;
  assign rem_o     = rem_q;
  assign dq_o      = dq_q;
  assign divisor_o = div_q;

endmodule

@@ hw/rtl/five_point_derivative_check.sv @@
// pipeline: two front stages, one stage per quotient bit of the restoring divider,
// one output register
// throughput: one word per cycle; the whole pipeline holds while the output word waits
// reset: asynchronous, active low; clears all valid bits and sets half_step to 1
// top level: stream ports, half_step register, divider chain, sign fix and output
`timescale 1ns / 1ps

module five_point_derivative_check #(
  parameter int unsigned SAMPLE_BITS   = 16,
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // far_left, near_left, mid, near_right, far_right, zero pad
  input  logic [((5*SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
  // invalid_mask
  input  logic [fpdc_pkg::MaskW-1:0]             s_axis_tuser,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // derivative, zero pad
  output logic [fpdc_pkg::OutTdataW-1:0]         m_axis_tdata,
  // status
  output logic [fpdc_pkg::StatusW-1:0]           m_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [fpdc_pkg::HalfStepW-1:0]         cfg_data_i
);

  import fpdc_pkg::*;

  localparam int unsigned MagW = SAMPLE_BITS + 4 + FRACTION_BITS;
  localparam int unsigned QW   = MagW + 1;

  logic                 en;
  logic [HalfStepW-1:0] half_step_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_step_q <= HalfStepRst;
    end else if (cfg_valid_i) begin
      half_step_q <= cfg_data_i;
    end
  end

  ctl_t                ctl_s [0:MagW];
  logic [DivisorW-1:0] rem_s [0:MagW];
  logic [MagW-1:0]     dq_s  [0:MagW];
  logic [DivisorW-1:0] div_s [0:MagW];

  fpdc_front #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (s_axis_tvalid),
    .far_left_i   (s_axis_tdata[0*SAMPLE_BITS +: SAMPLE_BITS]),
    .near_left_i  (s_axis_tdata[1*SAMPLE_BITS +: SAMPLE_BITS]),
    .mid_i        (s_axis_tdata[2*SAMPLE_BITS +: SAMPLE_BITS]),
    .near_right_i (s_axis_tdata[3*SAMPLE_BITS +: SAMPLE_BITS]),
    .far_right_i  (s_axis_tdata[4*SAMPLE_BITS +: SAMPLE_BITS]),
    .mask_i       (s_axis_tuser),
    .half_step_i  (half_step_q),
    .ctl_o        (ctl_s[0]),
    .mag_o        (dq_s[0]),
    .divisor_o    (div_s[0])
  );

  assign rem_s[0] = '0;

  for (genvar k = 0; k < MagW; k++) begin : g_div
    fpdc_div_step #(
      .MAG_W (MagW)
    ) u_step (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .ctl_i     (ctl_s[k]),
      .rem_i     (rem_s[k]),
      .dq_i      (dq_s[k]),
      .divisor_i (div_s[k]),
      .ctl_o     (ctl_s[k+1]),
      .rem_o     (rem_s[k+1]),
      .dq_o      (dq_s[k+1]),
      .divisor_o (div_s[k+1])
    );
  end

  // sign fix, truncation toward zero comes from dividing the magnitude
  logic signed [QW-1:0]     q_signed;
  logic signed [DerivW-1:0] q_fit;
  logic [DerivW-1:0]        deriv_d, deriv_q;
  ctl_t                     last;
  logic                     out_valid_q;
  status_e                  status_q;

  assign last     = ctl_s[MagW];
  assign q_signed = last.neg ? -QW'(dq_s[MagW]) : QW'(dq_s[MagW]);

  if (QW >= DerivW) begin : g_wrap
    assign q_fit = q_signed[DerivW-1:0];
  end else begin : g_extend
    assign q_fit = DerivW'(q_signed);
  end

  assign deriv_d = (last.status == ST_UNDEFINED) ? '0 : q_fit;

  assign en = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      deriv_q  <= deriv_d;
      status_q <= last.status;
    end
  end

  assign s_axis_tready = en;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutTdataW'(deriv_q);
  assign m_axis_tuser  = status_q;

endmodule

@@ verif/fpdc_checker.sv @@
// checker: predicts derivative and status of each window and compares them with output words
`timescale 1ns / 1ps

module fpdc_checker
  import fpdc_pkg::*;
#(
  parameter int unsigned SampleW = 16,
  parameter int unsigned FracW   = 8,
  parameter int unsigned InW     = 80
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // far_left, near_left, mid, near_right, far_right, zero pad
  input  logic [InW-1:0]       s_tdata_i,
  // invalid_mask
  input  logic [MaskW-1:0]     s_tuser_i,
  input  logic                 s_tvalid_i,
  input  logic                 s_tready_i,
  // derivative, zero pad
  input  logic [OutTdataW-1:0] m_tdata_i,
  // status
  input  logic [StatusW-1:0]   m_tuser_i,
  input  logic                 m_tvalid_i,
  input  logic                 m_tready_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [HalfStepW-1:0] cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  typedef struct packed {
    logic [DerivW-1:0] deriv;
    status_e           status;
  } outcome_t;

  outcome_t             pending_outcomes[$];
  outcome_t             want;
  logic [HalfStepW-1:0] half_step = HalfStepRst;
  int                   fail_count = 0;
  int                   pending = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;

  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic outcome_t derivative_of(input logic [InW-1:0] data,
                                             input logic [MaskW-1:0] mask,
                                             input logic [HalfStepW-1:0] h);
    outcome_t o;
    longint   f [5];
    longint   num;
    longint   div;
    logic     rise, fall, rh, lh;
    for (int i = 0; i < 5; i++) begin
      f[i] = longint'($signed(data[i*SampleW +: SampleW]));
    end
    o.deriv  = '0;
    o.status = ST_VALID;
    if (mask != '0) begin
      o.status = ST_UNDEFINED;
      return o;
    end
    // a zero half step counts as one
    div     = 12 * ((h == '0) ? longint'(1) : longint'(h));
    num     = (f[0] - 8 * f[1] + 8 * f[3] - f[4]) * (longint'(1) << FracW);
    o.deriv = DerivW'(num / div);
    rise = f[0] < f[1] && f[1] < f[2] && f[2] < f[3] && f[3] < f[4];
    fall = f[0] > f[1] && f[1] > f[2] && f[2] > f[3] && f[3] > f[4];
    if (!rise && !fall) begin
      rh = (f[3] > f[2] && f[3] > f[4]) || (f[3] < f[2] && f[3] < f[4]);
      lh = (f[1] > f[0] && f[1] > f[2]) || (f[1] < f[0] && f[1] < f[2]);
      if (rh && (lh || mag(2 * f[3] - f[2] - f[4]) > mag(f[2] - f[0]))) begin
        o.status = ST_UNSTABLE;
      end else if (lh && mag(2 * f[1] - f[0] - f[2]) > mag(f[4] - f[2])) begin
        o.status = ST_UNSTABLE;
      end
    end
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_step = HalfStepRst;
      pending_outcomes.delete();
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        pending_outcomes.push_back(derivative_of(s_tdata_i, s_tuser_i, half_step));
      end
      if (cfg_valid_i && cfg_ready_i) begin
        half_step = cfg_data_i;
      end
      if (m_tvalid_i && m_tready_i) begin
        if (pending_outcomes.size() == 0) begin
          fail_count++;
          $display("%0t: word with no window pending: expected none, actual tdata %h tuser %0d",
                   $time, m_tdata_i, m_tuser_i);
        end else begin
          want = pending_outcomes.pop_front();
          if (m_tdata_i !== OutTdataW'(want.deriv)) begin
            fail_count++;
            $display("%0t: derivative mismatch: expected %h, actual %h",
                     $time, OutTdataW'(want.deriv), m_tdata_i);
          end
          if (m_tuser_i !== want.status) begin
            fail_count++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, m_tuser_i);
          end
        end
      end
    end
    pending = pending_outcomes.size();
  end

endmodule

@@ verif/tb.sv @@
// testbench top: windows, half step settings, random idling and the verdict
`timescale 1ns / 1ps

module tb;
  import fpdc_pkg::*;

  localparam int SampleW        = 16;
  localparam int FracW          = 8;
  localparam int InW            = ((5 * SampleW + 7) / 8) * 8;
  localparam int Latency        = SampleW + FracW + 7;
  localparam int CycleLimit     = 1_000_000;
  localparam int WindowsInPhase = 245;
  localparam int Phases         = 8;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic [InW-1:0]       s_axis_tdata  = '0;
  logic [MaskW-1:0]     s_axis_tuser  = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic [StatusW-1:0]   m_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [HalfStepW-1:0] cfg_data_i    = '0;

  int fail_count;
  int pending;
  int cycles = 0;
  bit steady = 1'b0;

  // settings per phase; the last two are drawn at random
  logic [HalfStepW-1:0] step_plan [Phases] = '{16'd65535, 16'd1, 16'd0, 16'd12, 16'd2,
                                                16'd255, 16'd0, 16'd0};

  always #5 clk_i = ~clk_i;

  five_point_derivative_check #(
    .SAMPLE_BITS  (SampleW),
    .FRACTION_BITS(FracW)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  fpdc_checker #(
    .SampleW(SampleW),
    .FracW  (FracW),
    .InW    (InW)
  ) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tuser_i   (m_axis_tuser),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // mostly no gap, sometimes a short one, rarely a long one
  function automatic int idle_gap();
    int r;
    r = $urandom_range(99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 4);
  endfunction

  task automatic send_window(input logic signed [SampleW-1:0] f1, f2, f3, f4, f5,
                             input logic [MaskW-1:0] mask);
    int gap;
    s_axis_tdata  <= InW'({f5, f4, f3, f2, f1});
    s_axis_tuser  <= mask;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    gap = idle_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_random_window();
    logic signed [SampleW-1:0] w [5];
    logic signed [SampleW-1:0] t;
    logic [MaskW-1:0]          mask;
    int                        kind, d, level, i;
    kind = $urandom_range(99);
    mask = ($urandom_range(99) < 12) ? MaskW'($urandom_range(31, 1)) : '0;
    if (kind < 30) begin
      // strictly monotonic, rising or reversed to falling
      d     = $urandom_range(16383, 1);
      level = -32768 + int'($urandom_range(65535 - 4 * d));
      for (i = 0; i < 5; i++) begin
        w[i]  = SampleW'(level);
        level = level + int'($urandom_range(d, 1));
      end
      if ($urandom_range(1) == 1) begin
        for (i = 0; i < 2; i++) begin
          t        = w[i];
          w[i]     = w[4 - i];
          w[4 - i] = t;
        end
      end
    end else if (kind < 70) begin
      // samples close to one level: humps, ties and curvature near the bounds
      d     = ($urandom_range(1) == 1) ? 8 : 2000;
      level = int'($urandom_range(60000)) - 30000;
      for (i = 0; i < 5; i++) begin
        w[i] = SampleW'(level + int'($urandom_range(2 * d)) - d);
      end
    end else begin
      for (i = 0; i < 5; i++) begin
        w[i] = SampleW'($urandom);
      end
    end
    send_window(w[0], w[1], w[2], w[3], w[4], mask);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_half_step(input logic [HalfStepW-1:0] value);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // output side
  initial begin
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = idle_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(8, 1)) @(posedge clk_i);
    end
  end

  initial begin
    int phase;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed windows at the reset half step
    send_window(32767, 32767, 32767, 32767, 32767, 5'b00000);
    send_window(-32768, -32768, -32768, -32768, -32768, 5'b00000);
    send_window(32767, -32768, 0, 32767, -32768, 5'b00000);
    send_window(-32768, 32767, 0, -32768, 32767, 5'b00000);
    send_window(32767, -32768, 32767, -32768, 32767, 5'b00000);
    send_window(-32768, -100, 0, 100, 32767, 5'b00000);
    send_window(32767, 100, 0, -100, -32768, 5'b00000);
    send_window(1, 1, 1, 1, 1, 5'b00000);
    send_window(0, 1, 2, 2, 3, 5'b00000);
    // right hump, steep and shallow
    send_window(0, 1, 2, 100, 3, 5'b00000);
    send_window(-1000, -500, 0, 10, 5, 5'b00000);
    // left hump, steep and shallow
    send_window(0, 100, 1, 2, 3, 5'b00000);
    send_window(10, 15, 0, -500, -1000, 5'b00000);
    // humps on both sides, as peaks and as dips
    send_window(0, 5, 0, 5, 0, 5'b00000);
    send_window(0, -5, 0, -5, 0, 5'b00000);
    // flagged samples, one at a time and all together
    send_window(32767, -32768, 0, 32767, -32768, 5'b00001);
    send_window(32767, -32768, 0, 32767, -32768, 5'b00010);
    send_window(-32768, 32767, 0, -32768, 32767, 5'b00100);
    send_window(1, 2, 3, 4, 5, 5'b01000);
    send_window(0, 5, 0, 5, 0, 5'b10000);
    send_window(-1, -1, -1, -1, -1, 5'b11111);

    for (phase = 0; phase < Phases; phase++) begin
      wait_drained();
      write_half_step((phase < Phases - 2) ? step_plan[phase]
                                           : HalfStepW'($urandom_range(65535, 1)));
      steady = (phase % 3 == 2);
      repeat (WindowsInPhase) send_random_window();
    end

    wait_drained();
    repeat (Latency + 10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
